/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL. Synthesis builds define SYNTH to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GCLP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("gclp assertion failed");
`define GCLP_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("gclp forbidden condition");
`else
`define GCLP_ASSERT(lbl, clk, rstn, prop)
`define GCLP_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* rtl/core/gclp_pkg.sv */
package gclp_pkg;

    localparam int VALUE_BITS      = 32;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int NUM_WORDS       = 11;
    localparam int QUEUE_DEPTH     = 2;

    localparam int WORD_W   = 32;
    localparam int MANT_W   = VALUE_BITS - 1;
    localparam int FRAC_W   = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int CODE_W   = 16;
    localparam int WIDX_W   = $clog2(NUM_WORDS);
    localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [MANT_W-1:0] MAG_LIMIT  = {MANT_W{1'b1}};
    localparam logic [CODE_W-1:0] CODE_LIMIT = {CODE_W{1'b1}};

    // Character codes.
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CASE_MASK = 8'hDF;

    // Header letter codes.
    localparam logic [1:0] HDR_G       = 2'd0;
    localparam logic [1:0] HDR_M       = 2'd1;
    localparam logic [1:0] HDR_NEITHER = 2'd2;

    // Result kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_WORD   = 1'b1;

    typedef enum logic [5:0] {
        PH_HEAD    = 6'b000001,
        PH_SCAN    = 6'b000010,
        PH_VSTART  = 6'b000100,
        PH_VSIGN   = 6'b001000,
        PH_VDIGITS = 6'b010000,
        PH_DEAD    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic              hit;
        logic [WIDX_W-1:0] idx;
    } t_lookup;

    // One finished line handed from the parser to the emitter.
    typedef struct packed {
        logic [1:0]                         hdr_letter;
        logic                               hdr_valid;
        logic [CODE_W-1:0]                  hdr_number;
        logic [NUM_WORDS-1:0]               mask;
        logic [NUM_WORDS-1:0][WORD_W-1:0]   values;
        logic [NUM_WORDS-1:0][FRAC_W-1:0]   fracs;
    } t_line;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_decimal_word(input logic [WIDX_W-1:0] w);
        return (w >= WIDX_W'(5)) && (w <= WIDX_W'(9));
    endfunction

    // Parameter letter to word index, in the order I J K P S O X Y Z E F.
    function automatic t_lookup letter_lookup(input logic [7:0] c);
        t_lookup    r;
        logic [7:0] up;
        r  = '{hit: 1'b0, idx: '0};
        up = c & CASE_MASK;
        if (((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A))) begin
            r.hit = 1'b1;
            case (up)
                8'h49:   r.idx = WIDX_W'(0);
                8'h4A:   r.idx = WIDX_W'(1);
                8'h4B:   r.idx = WIDX_W'(2);
                8'h50:   r.idx = WIDX_W'(3);
                8'h53:   r.idx = WIDX_W'(4);
                8'h4F:   r.idx = WIDX_W'(5);
                8'h58:   r.idx = WIDX_W'(6);
                8'h59:   r.idx = WIDX_W'(7);
                8'h5A:   r.idx = WIDX_W'(8);
                8'h45:   r.idx = WIDX_W'(9);
                8'h46:   r.idx = WIDX_W'(10);
                default: r.hit = 1'b0;
            endcase
        end
        return r;
    endfunction

    // Mantissa times ten plus a digit, saturating at the magnitude limit.
    function automatic logic [MANT_W-1:0] mant_mac(input logic [MANT_W-1:0] m,
                                                   input logic [3:0] d);
        logic [MANT_W+3:0] t;
        t = ({1'b0, m, 3'b000} + {3'b000, m, 1'b0}) + (MANT_W+4)'(d);
        return (t > (MANT_W+4)'(MAG_LIMIT)) ? MAG_LIMIT : t[MANT_W-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] code_mac(input logic [CODE_W-1:0] h,
                                                   input logic [3:0] d);
        logic [CODE_W+3:0] t;
        t = ({1'b0, h, 3'b000} + {3'b000, h, 1'b0}) + (CODE_W+4)'(d);
        return (t > (CODE_W+4)'(CODE_LIMIT)) ? CODE_LIMIT : t[CODE_W-1:0];
    endfunction

    // Signed word value from sign and magnitude, as a two's complement result field.
    function automatic logic [WORD_W-1:0] make_value(input logic s,
                                                     input logic [MANT_W-1:0] m);
        logic signed [VALUE_BITS-1:0] v;
        v = s ? -$signed({1'b0, m}) : $signed({1'b0, m});
        return WORD_W'(v);
    endfunction

endpackage

/* rtl/core/gcode_line_word_parser.sv */
// G-code line word parser. Characters of one command line enter one per cycle
// on the input channel (i_valid/o_stall), the last one flagged by i_line_end;
// a new character is taken every cycle while the two-line queue between the
// parser and the result emitter has room. When a line ends the block emits a
// header transaction (G, M or neither, with the code number when a digit
// followed the letter) and then one transaction per valid parameter word in
// the order I J K P S O X Y Z E F, one per cycle while the receiver does not
// stall, with o_last on the final one. A line whose first character is not G
// or M yields only its header. Decimal words arrive as a saturated mantissa
// plus a count of fractional digits. A line has up to twelve results, and
// emitting them runs in parallel with parsing of the following lines.
module gcode_line_word_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_line_end,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_kind,
    output logic [3:0]         o_word_letter,
    output logic               o_code_valid,
    output logic [15:0]        o_code_number,
    output logic signed [31:0] o_word_value,
    output logic [3:0]         o_frac_digits,
    output logic               o_last
);

    logic            q_full, q_empty, push, pop, accept;
    gclp_pkg::t_line rec, head;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    gclp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .i_line_end  (i_line_end),
        .o_push      (push),
        .o_rec       (rec)
    );

    gclp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    gclp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_word_letter (o_word_letter),
        .o_code_valid  (o_code_valid),
        .o_code_number (o_code_number),
        .o_word_value  (o_word_value),
        .o_frac_digits (o_frac_digits),
        .o_last        (o_last)
    );

endmodule

/* rtl/core/gclp_front.sv */
module gclp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_char_code,
    input  logic               i_line_end,
    output logic               o_push,
    output gclp_pkg::t_line    o_rec
);

    logic [1:0]                        r_pos, n_pos;
    logic [1:0]                        r_hlet, n_hlet;
    logic                              r_hval, n_hval;
    logic [gclp_pkg::CODE_W-1:0]       r_hnum, n_hnum;
    gclp_pkg::t_phase                  r_phase, n_phase;
    logic [gclp_pkg::WIDX_W-1:0]       r_word, n_word;
    logic                              r_sign, n_sign;
    logic [gclp_pkg::MANT_W-1:0]       r_mant, n_mant;
    logic [gclp_pkg::FRAC_W-1:0]       r_frac, n_frac;
    logic                              r_point, n_point;
    logic [gclp_pkg::NUM_WORDS-1:0]    r_mask, n_mask;
    logic [gclp_pkg::NUM_WORDS-1:0][gclp_pkg::WORD_W-1:0] r_vals, n_vals;
    logic [gclp_pkg::NUM_WORDS-1:0][gclp_pkg::FRAC_W-1:0] r_fracs, n_fracs;

    logic                        dig;
    logic [3:0]                  dval;
    logic                        dec;
    gclp_pkg::t_lookup           lk;
    logic                        acc_ok;
    logic [gclp_pkg::MANT_W-1:0] mant_acc;
    logic [gclp_pkg::FRAC_W-1:0] frac_acc;
    logic                        end_req, end_ok, do_scan, do_add;

    // Character classification and the digit accumulators.
    assign dig      = gclp_pkg::is_digit(i_char_code);
    assign dval     = i_char_code[3:0];
    assign dec      = gclp_pkg::is_decimal_word(r_word);
    assign lk       = gclp_pkg::letter_lookup(i_char_code);
    assign acc_ok   = !r_point || (r_frac < gclp_pkg::FRAC_W'(gclp_pkg::MAX_FRAC_DIGITS));
    assign mant_acc = gclp_pkg::mant_mac(r_mant, dval);
    assign frac_acc = r_point ? r_frac + gclp_pkg::FRAC_W'(1) : r_frac;

    // Per-character state update, then line finish on the last character.
    always_comb begin
        n_pos   = r_pos;   n_hlet  = r_hlet;  n_hval  = r_hval;  n_hnum = r_hnum;
        n_phase = r_phase; n_word  = r_word;  n_sign  = r_sign;  n_mant = r_mant;
        n_frac  = r_frac;  n_point = r_point; n_mask  = r_mask;
        n_vals  = r_vals;  n_fracs = r_fracs;
        end_req = 1'b0;
        end_ok  = 1'b0;
        do_scan = 1'b0;
        do_add  = 1'b0;
        o_push  = 1'b0;
        o_rec   = '0;
        if (i_accept) begin
            case (r_phase)
                gclp_pkg::PH_HEAD: begin
                    if (r_pos == 2'd0) begin
                        if (i_char_code == gclp_pkg::CH_G) begin
                            n_hlet = gclp_pkg::HDR_G;
                        end else if (i_char_code == gclp_pkg::CH_M) begin
                            n_hlet = gclp_pkg::HDR_M;
                        end else begin
                            n_hlet  = gclp_pkg::HDR_NEITHER;
                            n_phase = gclp_pkg::PH_DEAD;
                        end
                    end else if (r_pos == 2'd1) begin
                        if (dig) begin
                            n_hval = 1'b1;
                            n_hnum = gclp_pkg::CODE_W'(dval);
                        end
                    end else if (dig) begin
                        n_hnum = gclp_pkg::code_mac(r_hnum, dval);
                    end else begin
                        n_phase = gclp_pkg::PH_SCAN;
                    end
                end
                gclp_pkg::PH_SCAN: begin
                    do_scan = 1'b1;
                end
                gclp_pkg::PH_VSTART: begin
                    if (i_char_code == gclp_pkg::CH_MINUS) begin
                        n_sign  = 1'b1;
                        n_phase = gclp_pkg::PH_VSIGN;
                    end else if (dig) begin
                        do_add  = 1'b1;
                        n_phase = gclp_pkg::PH_VDIGITS;
                    end else begin
                        end_req = 1'b1;
                        do_scan = 1'b1;
                    end
                end
                gclp_pkg::PH_VSIGN: begin
                    if (dig) begin
                        do_add  = 1'b1;
                        n_phase = gclp_pkg::PH_VDIGITS;
                    end else if (dec && (i_char_code == gclp_pkg::CH_POINT)) begin
                        n_point = 1'b1;
                        n_phase = gclp_pkg::PH_VDIGITS;
                    end else begin
                        end_req = 1'b1;
                        do_scan = 1'b1;
                    end
                end
                gclp_pkg::PH_VDIGITS: begin
                    if (dig) begin
                        do_add = 1'b1;
                    end else if (dec && (i_char_code == gclp_pkg::CH_POINT)) begin
                        if (r_point) begin
                            end_req = 1'b1;
                        end else begin
                            n_point = 1'b1;
                        end
                    end else begin
                        end_req = 1'b1;
                        end_ok  = 1'b1;
                        do_scan = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // Digit into the active value; digits past the fraction limit drop.
            if (do_add && acc_ok) begin
                n_mant = mant_acc;
                n_frac = frac_acc;
            end

            // Close the active word before a new letter may open another.
            if (end_req) begin
                n_phase = gclp_pkg::PH_SCAN;
                if (end_ok) begin
                    n_mask[n_word]  = 1'b1;
                    n_vals[n_word]  = gclp_pkg::make_value(n_sign, n_mant);
                    n_fracs[n_word] = n_frac;
                end else begin
                    n_mask[n_word] = 1'b0;
                end
            end

            if (do_scan && lk.hit) begin
                n_word  = lk.idx;
                n_sign  = 1'b0;
                n_mant  = '0;
                n_frac  = '0;
                n_point = 1'b0;
                n_phase = gclp_pkg::PH_VSTART;
            end

            if (r_pos != 2'd3) begin
                n_pos = r_pos + 2'd1;
            end

            // Last character: settle the open word, hand the line off, restart.
            if (i_line_end) begin
                if ((n_phase == gclp_pkg::PH_VSTART) || (n_phase == gclp_pkg::PH_VSIGN)) begin
                    n_mask[n_word] = 1'b0;
                end else if (n_phase == gclp_pkg::PH_VDIGITS) begin
                    n_mask[n_word]  = 1'b1;
                    n_vals[n_word]  = gclp_pkg::make_value(n_sign, n_mant);
                    n_fracs[n_word] = n_frac;
                end
                o_push           = 1'b1;
                o_rec.hdr_letter = n_hlet;
                o_rec.hdr_valid  = n_hval;
                o_rec.hdr_number = n_hnum;
                o_rec.mask       = n_mask;
                o_rec.values     = n_vals;
                o_rec.fracs      = n_fracs;
                n_pos   = 2'd0;
                n_hlet  = gclp_pkg::HDR_NEITHER;
                n_hval  = 1'b0;
                n_hnum  = '0;
                n_phase = gclp_pkg::PH_HEAD;
                n_word  = '0;
                n_sign  = 1'b0;
                n_mant  = '0;
                n_frac  = '0;
                n_point = 1'b0;
                n_mask  = '0;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_hlet  <= gclp_pkg::HDR_NEITHER;
            r_hval  <= 1'b0;
            r_hnum  <= '0;
            r_phase <= gclp_pkg::PH_HEAD;
            r_word  <= '0;
            r_sign  <= 1'b0;
            r_mant  <= '0;
            r_frac  <= '0;
            r_point <= 1'b0;
            r_mask  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_hlet  <= n_hlet;
            r_hval  <= n_hval;
            r_hnum  <= n_hnum;
            r_phase <= n_phase;
            r_word  <= n_word;
            r_sign  <= n_sign;
            r_mant  <= n_mant;
            r_frac  <= n_frac;
            r_point <= n_point;
            r_mask  <= n_mask;
        end
    end

    // Word store; entries are only read where their mask bit is set.
    always_ff @(posedge i_clk) begin
        r_vals  <= n_vals;
        r_fracs <= n_fracs;
    end

endmodule

/* rtl/core/gclp_queue.sv */
`include "assert_macros.svh"

module gclp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gclp_pkg::t_line    i_rec,
    input  logic               i_pop,
    output gclp_pkg::t_line    o_head,
    output logic               o_empty,
    output logic               o_full
);

    gclp_pkg::t_line                  r_mem [gclp_pkg::QUEUE_DEPTH];
    logic [gclp_pkg::QPTR_W-1:0]      r_wp, r_rp;
    logic [gclp_pkg::QCNT_W-1:0]      r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == gclp_pkg::QCNT_W'(gclp_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rp];

    // Line records.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == gclp_pkg::QPTR_W'(gclp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wp + gclp_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == gclp_pkg::QPTR_W'(gclp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rp + gclp_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + gclp_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - gclp_pkg::QCNT_W'(1);
            end
        end
    end

    `GCLP_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full)
    `GCLP_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_empty)
    `GCLP_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= gclp_pkg::QCNT_W'(gclp_pkg::QUEUE_DEPTH))
    `GCLP_ASSERT(a_cnt_step, i_clk, i_rst_n, (i_push && !i_pop) |=> !o_empty)

endmodule

/* rtl/core/gclp_back.sv */
module gclp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gclp_pkg::t_line               i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic [3:0]                    o_word_letter,
    output logic                          o_code_valid,
    output logic [15:0]                   o_code_number,
    output logic signed [31:0]            o_word_value,
    output logic [3:0]                    o_frac_digits,
    output logic                          o_last
);

    logic                              r_hdr_pend;
    logic [gclp_pkg::NUM_WORDS-1:0]    r_rem;
    logic                              r_valid;
    logic                              r_kind, r_cval, r_last;
    logic [3:0]                        r_letter, r_frac4;
    logic [15:0]                       r_cnum;
    logic [31:0]                       r_value;

    logic                              load;
    logic [gclp_pkg::NUM_WORDS-1:0]    hdr_rem, pick, word_rem;
    logic [gclp_pkg::WIDX_W-1:0]       idx;
    logic                              n_last;

    assign load    = !i_empty && (!r_valid || !i_stall);
    assign hdr_rem = (i_head.hdr_letter == gclp_pkg::HDR_NEITHER) ? '0 : i_head.mask;
    assign pick    = r_rem & (~r_rem + gclp_pkg::NUM_WORDS'(1));
    assign word_rem = r_rem & ~pick;
    assign n_last  = r_hdr_pend ? (hdr_rem == '0) : (word_rem == '0);
    assign o_pop   = load && n_last;

    // Index of the lowest pending word.
    always_comb begin
        idx = '0;
        for (int k = 0; k < gclp_pkg::NUM_WORDS; k++) begin
            if (pick[k]) begin
                idx = idx | gclp_pkg::WIDX_W'(k);
            end
        end
    end

    // Emission sequence: header first, then pending words lowest index first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pend <= 1'b1;
            r_rem      <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (!r_valid || !i_stall) begin
                r_valid <= !i_empty;
            end
            if (load) begin
                if (n_last) begin
                    r_hdr_pend <= 1'b1;
                    r_rem      <= '0;
                end else if (r_hdr_pend) begin
                    r_hdr_pend <= 1'b0;
                    r_rem      <= hdr_rem;
                end else begin
                    r_rem <= word_rem;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last <= n_last;
            if (r_hdr_pend) begin
                r_kind   <= gclp_pkg::KIND_HEADER;
                r_letter <= {2'b00, i_head.hdr_letter};
                r_cval   <= i_head.hdr_valid;
                r_cnum   <= i_head.hdr_valid ? i_head.hdr_number : 16'd0;
                r_value  <= 32'd0;
                r_frac4  <= 4'd0;
            end else begin
                r_kind   <= gclp_pkg::KIND_WORD;
                r_letter <= 4'(idx);
                r_cval   <= 1'b0;
                r_cnum   <= 16'd0;
                r_value  <= i_head.values[idx];
                r_frac4  <= gclp_pkg::is_decimal_word(idx) ? 4'(i_head.fracs[idx]) : 4'd0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_word_letter = r_letter;
    assign o_code_valid  = r_cval;
    assign o_code_number = r_cnum;
    assign o_word_value  = $signed(r_value);
    assign o_frac_digits = r_frac4;
    assign o_last        = r_last;

endmodule

/* tb/gcode_line_word_parser_test.sv */
module gcode_line_word_parser_test;

    localparam int N_WORDS = 11;
    localparam logic [31:0] MAG_MAX = 32'h7FFF_FFFF;

    // Parser phases of the line model.
    typedef enum int {
        P_HEAD, P_SCAN, P_VSTART, P_VSIGN, P_VDIGITS, P_DEAD
    } t_pphase;

    // One result transaction as it leaves the block.
    typedef struct {
        logic        kind;
        logic [3:0]  letter;
        logic        cvalid;
        logic [15:0] cnum;
        logic [31:0] value;
        logic [3:0]  frac;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_line_end = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic        o_kind;
    logic [3:0]  o_word_letter;
    logic        o_code_valid;
    logic [15:0] o_code_number;
    logic signed [31:0] o_word_value;
    logic [3:0]  o_frac_digits;
    logic        o_last;

    gcode_line_word_parser DUT (.*);

    always #6 i_clk = ~i_clk;

    // Line model state.
    int          pos_cnt;
    logic [1:0]  hdr_let;
    logic        hdr_ok;
    logic [15:0] hdr_num;
    t_pphase     phase;
    int          cur_word;
    logic        cur_neg;
    logic [31:0] cur_mag;
    int          cur_frac;
    logic        cur_point;
    logic [31:0] word_val [N_WORDS];
    int          word_frac [N_WORDS];
    logic [N_WORDS-1:0] word_ok;

    t_result expected_results[$];
    int      errors = 0;
    int      lines_sent = 0;
    int      results_seen = 0;
    int      chars_sent = 0;
    bit      rx_hold = 1'b0;
    bit      no_idle = 1'b0;

    function automatic bit digit_c(logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic bit dec_word(int w);
        return w >= 5 && w <= 9;
    endfunction

    task automatic line_clear();
        pos_cnt = 0; hdr_let = gclp_pkg::HDR_NEITHER; hdr_ok = 0; hdr_num = 0;
        phase = P_HEAD; cur_word = 0; cur_neg = 0; cur_mag = 0; cur_frac = 0;
        cur_point = 0; word_ok = '0;
        for (int k = 0; k < N_WORDS; k++) begin
            word_val[k] = 0; word_frac[k] = 0;
        end
    endtask

    task automatic push_digit(logic [7:0] c);
        longint m;
        if (cur_point) begin
            if (cur_frac >= 9) return;
            cur_frac++;
        end
        m = longint'(cur_mag) * 10 + (c - 8'd48);
        cur_mag = (m > MAG_MAX) ? MAG_MAX : m[31:0];
    endtask

    task automatic close_word(bit ok);
        if (ok) begin
            word_ok[cur_word] = 1'b1;
            word_val[cur_word] = cur_neg ? -cur_mag : cur_mag;
            word_frac[cur_word] = cur_frac;
        end else begin
            word_ok[cur_word] = 1'b0;
        end
        phase = P_SCAN;
    endtask

    task automatic open_word(logic [7:0] c);
        gclp_pkg::t_lookup lk;
        lk = gclp_pkg::letter_lookup(c);
        if (lk.hit) begin
            cur_word = lk.idx; cur_neg = 0; cur_mag = 0; cur_frac = 0;
            cur_point = 0; phase = P_VSTART;
        end
    endtask

    // Advance the line model by one character and queue any results.
    task automatic predict_char(logic [7:0] c, logic eol);
        bit dec;
        int m;
        t_result r;
        dec = dec_word(cur_word);
        case (phase)
            P_HEAD: begin
                if (pos_cnt == 0) begin
                    if (c == gclp_pkg::CH_G) hdr_let = gclp_pkg::HDR_G;
                    else if (c == gclp_pkg::CH_M) hdr_let = gclp_pkg::HDR_M;
                    else begin
                        hdr_let = gclp_pkg::HDR_NEITHER; phase = P_DEAD;
                    end
                end else if (pos_cnt == 1) begin
                    if (digit_c(c)) begin
                        hdr_ok = 1; hdr_num = c - 8'd48;
                    end
                end else if (digit_c(c)) begin
                    m = int'(hdr_num) * 10 + (c - 8'd48);
                    hdr_num = (m > 65535) ? 16'hFFFF : m[15:0];
                end else begin
                    phase = P_SCAN;
                end
            end
            P_SCAN: open_word(c);
            P_VSTART: begin
                if (c == gclp_pkg::CH_MINUS) begin
                    cur_neg = 1; phase = P_VSIGN;
                end else if (digit_c(c)) begin
                    push_digit(c); phase = P_VDIGITS;
                end else begin
                    close_word(0); open_word(c);
                end
            end
            P_VSIGN: begin
                if (digit_c(c)) begin
                    push_digit(c); phase = P_VDIGITS;
                end else if (dec && c == gclp_pkg::CH_POINT) begin
                    cur_point = 1; phase = P_VDIGITS;
                end else begin
                    close_word(0); open_word(c);
                end
            end
            P_VDIGITS: begin
                if (digit_c(c)) push_digit(c);
                else if (dec && c == gclp_pkg::CH_POINT) begin
                    if (cur_point) close_word(0);
                    else cur_point = 1;
                end else begin
                    close_word(1); open_word(c);
                end
            end
            default: ;
        endcase
        if (pos_cnt < 255) pos_cnt++;
        if (!eol) return;
        if (phase == P_VSTART || phase == P_VSIGN) close_word(0);
        else if (phase == P_VDIGITS) close_word(1);
        r = '{kind: gclp_pkg::KIND_HEADER, letter: 4'(hdr_let), cvalid: hdr_ok,
              cnum: hdr_ok ? hdr_num : 16'd0, value: 0, frac: 0, last: 0};
        expected_results.push_back(r);
        if (hdr_let != gclp_pkg::HDR_NEITHER) begin
            for (int w = 0; w < N_WORDS; w++) begin
                if (word_ok[w]) begin
                    r = '{kind: gclp_pkg::KIND_WORD, letter: 4'(w), cvalid: 0, cnum: 0,
                          value: word_val[w],
                          frac: dec_word(w) ? 4'(word_frac[w]) : 4'd0, last: 0};
                    expected_results.push_back(r);
                end
            end
        end
        expected_results[$].last = 1'b1;
        lines_sent++;
        line_clear();
    endtask

    // Send one character transaction, with optional idle cycles first.
    // Valid stays high afterwards so the next character can follow directly.
    task automatic send_char(logic [7:0] c, logic eol);
        while (!no_idle && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= c;
        i_line_end <= eol;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_char(c, eol);
        chars_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid when the sender pauses.
    task automatic stop_input();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_line(string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'd48 + 8'($urandom_range(9));
    endfunction

    // A well-formed line with random words, sometimes damaged.
    function automatic string rand_line();
        string s, lets, num;
        int nw;
        lets = "IJKPSOXYZEFijkpsoxyzef";
        s = ($urandom_range(1)) ? "G" : "M";
        for (int k = $urandom_range(1, 6); k > 0; k--) s = {s, string'(rand_digit())};
        s = {s, " "};
        nw = $urandom_range(0, 6);
        for (int k = 0; k < nw; k++) begin
            num = "";
            if ($urandom_range(3) == 0) num = "-";
            for (int d = $urandom_range(1, 12); d > 0; d--) num = {num, string'(rand_digit())};
            if ($urandom_range(2) == 0) begin
                num = {num, "."};
                for (int d = $urandom_range(0, 11); d > 0; d--)
                    num = {num, string'(rand_digit())};
            end
            s = {s, string'(lets[$urandom_range(lets.len() - 1)]), num};
            if ($urandom_range(1)) s = {s, " "};
        end
        if ($urandom_range(4) == 0) begin
            // Damage one position with an arbitrary byte.
            int p;
            p = $urandom_range(s.len() - 1);
            s[p] = 8'($urandom_range(1, 255));
        end
        if (s.len() > 40) s = s.substr(0, 39);
        return s;
    endfunction

    task automatic drain_wait();
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    // Receiver stall pattern, with a long hold-off when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b1;
        else if (rx_hold) i_stall <= 1'b1;
        else if (no_idle) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 31);
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind=%0d letter=%0d value=%0d", $time,
                         o_kind, o_word_letter, o_word_value);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_kind !== e.kind || o_word_letter !== e.letter ||
                    o_code_valid !== e.cvalid || o_code_number !== e.cnum ||
                    o_word_value !== e.value || o_frac_digits !== e.frac ||
                    o_last !== e.last) begin
                    $display("%0t: mismatch expected k=%0d l=%0d cv=%0d cn=%0d v=%0d f=%0d last=%0d",
                             $time, e.kind, e.letter, e.cvalid, e.cnum,
                             $signed(e.value), e.frac, e.last);
                    $display("%0t:          actual   k=%0d l=%0d cv=%0d cn=%0d v=%0d f=%0d last=%0d",
                             $time, o_kind, o_word_letter, o_code_valid, o_code_number,
                             o_word_value, o_frac_digits, o_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("gcode_line_word_parser regression: fail");
        $finish;
    end

    // Directed lines; the first rows carry hand-written header expectations.
    string dir_lines[] = '{
        "Q17 X1",           // bad header letter
        "G",                // letter alone
        "M99999999",        // code saturates
        "GX X5",            // missing code digit
        "G1 X1.5 Y-2.25 Z-.5 E.",
        "G0 I-3 J K- P7 S0 F12",
        "G1 X1..2 Y3",      // second point
        "G1 X9 X Y1 Y2",    // repeated letters
        "M3 S99999999999 O0.1234567891234",
        "g1 x1 G1 i5 f-",   // lowercase and ending on a minus
        "G1 X-"
    };

    initial begin
        int n, cyc;
        t_result r;
        line_clear();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        no_idle = 1'b1;
        for (int k = 0; k < dir_lines.size(); k++) begin
            send_line(dir_lines[k]);
            if (k < 3) begin
                // These lines yield only a header, so it is the newest expectation.
                r = expected_results[$];
                if ((k == 0 && !(r.letter == 4'(gclp_pkg::HDR_NEITHER) && !r.cvalid && r.last)) ||
                    (k == 1 && !(r.letter == 4'(gclp_pkg::HDR_G) && !r.cvalid)) ||
                    (k == 2 && !(r.letter == 4'(gclp_pkg::HDR_M) && r.cnum == 16'hFFFF))) begin
                    $display("%0t: directed header row %0d disagrees with model", $time, k);
                    errors++;
                end
            end
            if (k == 4) no_idle = 1'b0;
        end
        // Single-character lines with the highest and the lowest byte value.
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
        stop_input();
        drain_wait();
        // Long receiver hold-off while lines keep coming in.
        rx_hold = 1'b1;
        fork
            begin
                cyc = 0;
                while (cyc < 200) begin
                    @(negedge i_clk);
                    cyc++;
                end
                rx_hold = 1'b0;
            end
            for (int k = 0; k < 4; k++) send_line(rand_line());
        join
        stop_input();
        drain_wait();
        n = 0;
        while (chars_sent < 470) begin
            if (n == 1) no_idle = 1'b1;
            if (n == 4) no_idle = 1'b0;
            if ($urandom_range(9) == 0) begin
                // Noise line of arbitrary bytes.
                for (int k = $urandom_range(1, 8); k > 0; k--)
                    send_char(8'($urandom_range(255)), k == 1);
            end else begin
                send_line(rand_line());
            end
            n++;
        end
        stop_input();
        drain_wait();
        repeat (30) @(negedge i_clk);
        $display("Sent %0d characters in %0d lines; %0d results checked.",
                 chars_sent, lines_sent, results_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("gcode_line_word_parser regression: pass");
        else
            $display("gcode_line_word_parser regression: fail");
        $finish;
    end

endmodule
